// ===== sv/printer_shift_code_encoder_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PRINTER_SHIFT_CODE_ENCODER_TOP_MACROS_SVH
`define PRINTER_SHIFT_CODE_ENCODER_TOP_MACROS_SVH

// Checked on every clock edge outside of reset.
`define PSCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PSCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/psce_pkg.sv =====
package psce_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PadW  = 3;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 3;

  typedef logic [CharW-1:0] char_t;
  typedef logic [PadW-1:0]  pad_t;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] REG_FOLD_LOWERCASE = 1'd0;
  localparam logic [CfgAddrW-1:0] REG_PAD_COUNT      = 1'd1;

  localparam char_t SHIFT_IN  = 8'h0F;
  localparam char_t SHIFT_OUT = 8'h0E;
  localparam char_t PAD_BYTE  = 8'h80;
  localparam char_t NEWLINE   = 8'h0A;
  localparam char_t CAR_RET   = 8'h0D;
  localparam char_t CASE_BIT  = 8'h20;

  // What one input character turns into.
  typedef struct packed {
    logic  zero;        // drops without any output
    char_t first_byte;  // first byte to send
    char_t ch;          // folded character
    logic  has_prefix;  // a shift byte goes before the character
    logic  nl;          // CR and padding follow the character
    logic  last;        // first byte is the only byte
    logic  mode_nxt;    // Russian mode after this item
  } dec_t;

endpackage

// ===== sv/printer_shift_code_encoder_top.sv =====
// An item goes from the input register through the decoder into the output register.
// Throughput: one item per cycle while each gives one byte and out_tready is high; an item
// that gives k bytes holds the output register until all k are taken (up to nine for a newline with seven pads).
// The input register takes the next item while earlier bytes still drain.
// Reset (rst_n low, synchronous) empties both registers, returns to Latin mode,
// and sets folding on and the pad count to four.
module printer_shift_code_encoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] char_in
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] char_out
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [psce_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [psce_pkg::CfgDataW-1:0]   cfg_wdata
);

  logic fold_r;
  psce_pkg::pad_t pad_count_r;
  logic mode_r;

  logic            inq_valid_r;
  psce_pkg::char_t inq_char_r;

  // Bytes still owed by the item in progress.
  logic            ch_pend_r;
  psce_pkg::char_t ch_r;
  logic            cr_pend_r;
  psce_pkg::pad_t  pad_left_r;

  logic            out_valid_r;
  psce_pkg::char_t out_data_r;
  logic            out_last_r;

  psce_pkg::dec_t dec;
  logic out_free;
  logic busy;
  logic take;

  psce_decode u_decode (
    .char_in        (inq_char_r),
    .fold_lowercase (fold_r),
    .russian_mode   (mode_r),
    .dec            (dec)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign busy      = ch_pend_r || cr_pend_r || (pad_left_r != '0);
  assign take      = inq_valid_r && !busy && (dec.zero || out_free);
  assign in_tready = !inq_valid_r || take;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r      <= 1'b1;
      pad_count_r <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_addr)
        psce_pkg::REG_FOLD_LOWERCASE: fold_r      <= cfg_wdata[0];
        psce_pkg::REG_PAD_COUNT:      pad_count_r <= cfg_wdata[psce_pkg::PadW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_tready) begin
      inq_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      inq_char_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      ch_pend_r   <= 1'b0;
      cr_pend_r   <= 1'b0;
      pad_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (busy && out_free) begin
      // Drain the item in progress: character, then CR, then padding.
      out_valid_r <= 1'b1;
      if (ch_pend_r) begin
        ch_pend_r <= 1'b0;
      end else if (cr_pend_r) begin
        cr_pend_r <= 1'b0;
      end else begin
        pad_left_r <= pad_left_r - 3'd1;
      end
    end else if (take && !dec.zero) begin
      mode_r      <= dec.mode_nxt;
      ch_pend_r   <= dec.has_prefix;
      cr_pend_r   <= dec.nl;
      pad_left_r  <= dec.nl ? pad_count_r : '0;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      if (ch_pend_r) begin
        out_data_r <= ch_r;
        out_last_r <= !cr_pend_r && (pad_left_r == '0);
      end else if (cr_pend_r) begin
        out_data_r <= psce_pkg::CAR_RET;
        out_last_r <= (pad_left_r == '0);
      end else begin
        out_data_r <= psce_pkg::PAD_BYTE;
        out_last_r <= (pad_left_r == 3'd1);
      end
    end else if (take && !dec.zero) begin
      out_data_r <= dec.first_byte;
      out_last_r <= dec.last;
      ch_r       <= dec.ch;
    end
  end

endmodule

// ===== sv/psce_decode.sv =====
module psce_decode (
  input  psce_pkg::char_t char_in,
  input  logic            fold_lowercase,
  input  logic            russian_mode,
  output psce_pkg::dec_t  dec
);

  psce_pkg::char_t c;
  logic is_lower;
  logic is_latin;
  logic is_cyr;
  logic do_so;
  logic do_si;

  always_comb begin
    is_lower = ((char_in >= 8'h61) && (char_in <= 8'h7A)) ||
               ((char_in >= 8'hC0) && (char_in <= 8'hDF));
    c = (fold_lowercase && is_lower) ? (char_in ^ psce_pkg::CASE_BIT) : char_in;
    is_latin = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    is_cyr   = (c >= 8'hE0) && (c <= 8'hFE);
    do_so = is_cyr && !russian_mode;
    do_si = is_latin && russian_mode;

    dec.zero       = (char_in == '0);
    dec.ch         = c;
    dec.has_prefix = do_so || do_si;
    dec.nl         = (c == psce_pkg::NEWLINE);
    dec.last       = !(do_so || do_si) && (c != psce_pkg::NEWLINE);
    if (do_so) begin
      dec.first_byte = psce_pkg::SHIFT_OUT;
    end else if (do_si) begin
      dec.first_byte = psce_pkg::SHIFT_IN;
    end else begin
      dec.first_byte = c;
    end

    // An explicit shift character sets the mode the same way as a prefix.
    if (do_so || (c == psce_pkg::SHIFT_OUT)) begin
      dec.mode_nxt = 1'b1;
    end else if (do_si || (c == psce_pkg::SHIFT_IN)) begin
      dec.mode_nxt = 1'b0;
    end else begin
      dec.mode_nxt = russian_mode;
    end
  end

endmodule

// ===== sv/psce_checker.sv =====
`include "printer_shift_code_encoder_top_macros.svh"

module psce_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // A stalled byte stays put until it is taken.
  `PSCE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output byte changed while stalled")

  // A newline is always followed by its carriage return.
  `PSCE_ASSERT(a_nl_not_last, out_tvalid && (out_tdata == psce_pkg::NEWLINE) |-> !out_tlast, "newline marked as last byte")

  // Zero characters are dropped, and nothing folds to zero.
  `PSCE_ASSERT(a_no_zero, out_tvalid |-> (out_tdata != 8'h00), "zero byte sent")

  `PSCE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

bind printer_shift_code_encoder_top psce_checker u_psce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== sim/tb.sv =====
module tb;
  import psce_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 4;
  localparam int unsigned LongHold   = 300;

  localparam char_t CYR_LO      = 8'hE0;
  localparam char_t CYR_HI      = 8'hFE;
  localparam char_t LOW_CYR_LO  = 8'hC0;
  localparam char_t LOW_CYR_HI  = 8'hDF;

  typedef struct {
    char_t val;
    logic  last;
  } out_byte_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;     // [7:0] char_in
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;         // [7:0] char_out
  logic                out_tlast;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Testbench copy of the block's registers and shift state.
  logic fold_on = 1'b1;
  pad_t pad_n = 3'd4;
  logic rus_mode = 1'b0;

  char_t     char_feed_q[$];
  out_byte_t printer_bytes_q[$];

  int unsigned fed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  char_t dir_defaults[$] = '{8'h00, 8'h61, 8'h7A, 8'h41, 8'h5A, 8'hC0, 8'hFE, 8'hDF,
                             8'h71, 8'hE0, 8'h0F, 8'h0E, 8'h42, 8'h0A, 8'hFF};
  char_t dir_nofold[$]   = '{8'hC5, 8'hE1, 8'h61, 8'hD0, 8'h0A, 8'hE5, 8'hC0, 8'h0F};
  char_t dir_maxpad[$]   = '{8'h0A, 8'h60};

  printer_shift_code_encoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic bit is_latin_letter(input char_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_lower_case(input char_t c);
    return (c >= "a" && c <= "z") || (c >= LOW_CYR_LO && c <= LOW_CYR_HI);
  endfunction

  // Appends the printer bytes that one character turns into.
  function automatic void encode_char(input char_t raw);
    char_t     c;
    char_t     seq[$];
    out_byte_t rec;
    c = raw;
    if (c == 8'h00) return;
    if (fold_on && is_lower_case(c)) c = c ^ CASE_BIT;
    if (c >= CYR_LO && c <= CYR_HI && !rus_mode) begin
      seq.push_back(SHIFT_OUT);
      rus_mode = 1'b1;
    end
    if (is_latin_letter(c) && rus_mode) begin
      seq.push_back(SHIFT_IN);
      rus_mode = 1'b0;
    end
    if (c == SHIFT_IN) rus_mode = 1'b0;
    if (c == SHIFT_OUT) rus_mode = 1'b1;
    seq.push_back(c);
    if (c == NEWLINE) begin
      seq.push_back(CAR_RET);
      for (int i = 0; i < int'(pad_n); i++) seq.push_back(PAD_BYTE);
    end
    foreach (seq[i]) begin
      rec.val  = seq[i];
      rec.last = (i == seq.size() - 1);
      printer_bytes_q.push_back(rec);
    end
  endfunction

  // Biased toward letters, the Cyrillic block, newlines and shift codes.
  function automatic char_t pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      if ($urandom_range(0, 1)) return char_t'("a" + $urandom_range(0, 25));
      return char_t'("A" + $urandom_range(0, 25));
    end
    if (r < 45) return char_t'($urandom_range(LOW_CYR_LO, 8'hFF));
    if (r < 55) return NEWLINE;
    if (r < 60) return $urandom_range(0, 1) ? SHIFT_IN : SHIFT_OUT;
    if (r < 63) return 8'h00;
    return char_t'($urandom_range(0, 255));
  endfunction

  task automatic feed(input char_t c);
    char_feed_q.push_back(c);
    fed_cnt++;
  endtask

  // Waits until every fed item is taken and every byte is out, then lets a
  // possible trailing zero item clear the pipeline.
  task automatic drain();
    while (accepted_cnt != fed_cnt || printer_bytes_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FOLD_LOWERCASE) fold_on = val[0];
    else pad_n = pad_t'(val);
  endtask

  always @(posedge clk) begin : tx_side
    char_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_char(in_tdata);
        accepted_cnt++;
        if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (char_feed_q.size() > 0) begin
          nxt = char_feed_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx_side
    out_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (printer_bytes_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected output byte %h last %b", out_tdata, out_tlast);
        end else begin
          want = printer_bytes_q.pop_front();
          if (out_tdata !== want.val || out_tlast !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("byte mismatch: expected %h last %b, got %h last %b",
                       want.val, want.last, out_tdata, out_tlast);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: folding on, four pads.
    foreach (dir_defaults[i]) feed(dir_defaults[i]);
    drain();

    write_reg(REG_FOLD_LOWERCASE, 3'd0);
    write_reg(REG_PAD_COUNT, 3'd0);
    foreach (dir_nofold[i]) feed(dir_nofold[i]);
    drain();

    write_reg(REG_FOLD_LOWERCASE, 3'd1);
    write_reg(REG_PAD_COUNT, 3'd7);
    foreach (dir_maxpad[i]) feed(dir_maxpad[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_FOLD_LOWERCASE, (ph == 0) ? 3'd0 : 3'($urandom_range(0, 1)));
      write_reg(REG_PAD_COUNT, (ph == 0) ? 3'd7 : 3'($urandom_range(0, 7)));
      // The last phase runs at full rate on both sides.
      if (ph == 4) idle_on = 1'b0;
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < 38; k++) begin
        feed(pick_char());
        // Sender stops halfway through this phase until the output is empty.
        if (ph == 2 && k == 18) drain();
      end
      drain();
    end

    if (fail_cnt == 0 && printer_bytes_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/psce_pkg.sv
sv/psce_decode.sv
sv/printer_shift_code_encoder_top.sv
sv/psce_checker.sv
sim/tb.sv
